[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable max priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] prio;
    logic signed [WORD_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    status_t                  status;
  } res_t;

endpackage

`default_nettype wire

[hdl/stable_max_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_max_priority_queue
// Bounded max-priority queue, earliest entry wins among equal priorities.
// ----------------------------------------------------------------------------
// One request is taken at a time. An enqueue writes its entry and then
// hands off its result; a request that ends in an empty or full status
// hands off its result at once. A dequeue scans all stored entries, then
// closes the gap left by the winner unless it is the last entry: the
// entries are read one per cycle through the single read port of the entry
// memory and checked by one comparator, then the later entries are moved
// down one slot per cycle. A finished result sits in an output register, so
// the next request is taken while it waits.
`default_nettype none

module stable_max_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_data_in,
  input  wire logic signed [31:0] in_priority_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_data_out,
  output logic [1:0]              out_status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_pkg::entry_t req_entry;
  spq_pkg::entry_t wr_entry;
  spq_pkg::entry_t rd_entry;
  spq_pkg::res_t   res;
  spq_pkg::res_t   out_res_r;
  logic            out_vld_r;
  logic            res_valid;
  logic            res_take;
  logic            wr_en;
  logic            rd_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  assign req_entry.prio = in_priority_in;
  assign req_entry.data = in_data_in;

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_vld_r || !out_stall;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req_op    (in_operation),
    .req_entry (req_entry),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_data_out = out_res_r.data_out;
  assign out_status   = out_res_r.status;

endmodule

`default_nettype wire

[hdl/spq_mem.sv]
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire spq_pkg::entry_t  wr_entry,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output spq_pkg::entry_t       rd_entry
);

  spq_pkg::entry_t mem [DEPTH];
  spq_pkg::entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

[hdl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: enqueue write, pipelined max scan with one comparator,
// close-up shift after removal, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 req_op,
  input  wire spq_pkg::entry_t      req_entry,
  output logic                      res_valid,
  input  wire logic                 res_take,
  output spq_pkg::res_t             res,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output spq_pkg::entry_t           wr_entry,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire spq_pkg::entry_t      rd_entry
);

  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  spq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            rvld_r, rvld_nxt;
  logic [AW-1:0]   ridx_r, ridx_nxt;
  logic [AW-1:0]   best_idx_r, best_idx_nxt;
  logic signed [spq_pkg::WORD_W-1:0] best_pri_r, best_pri_nxt;
  logic signed [spq_pkg::WORD_W-1:0] best_data_r, best_data_nxt;
  spq_pkg::entry_t hold_r, hold_nxt;
  spq_pkg::res_t   res_r, res_nxt;

  logic accept;
  logic is_deq;
  logic issue;
  logic take_best;
  logic scan_last;
  logic shift_done;

  assign accept     = req_valid && (state_r == spq_pkg::S_IDLE);
  assign is_deq     = (req_op == spq_pkg::OP_DEQ);
  assign issue      = (ptr_r < cnt_r);
  // shared compare unit
  assign take_best  = rvld_r && ((ridx_r == '0) || (rd_entry.prio > best_pri_r));
  assign scan_last  = rvld_r && (CW'(ridx_r) == (cnt_r - CW'(1)));
  assign shift_done = !issue && !rvld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_deq) begin
            state_nxt = (cnt_r == '0) ? spq_pkg::S_RESP : spq_pkg::S_SCAN;
          end else begin
            state_nxt = (cnt_r == CNT_FULL) ? spq_pkg::S_RESP : spq_pkg::S_ENQ;
          end
        end
      end
      spq_pkg::S_ENQ:   state_nxt = spq_pkg::S_RESP;
      spq_pkg::S_SCAN:  if (scan_last) state_nxt = spq_pkg::S_SHIFT;
      spq_pkg::S_SHIFT: if (shift_done) state_nxt = spq_pkg::S_RESP;
      spq_pkg::S_RESP:  if (res_take) state_nxt = spq_pkg::S_IDLE;
      default:          state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    rvld_nxt      = 1'b0;
    ridx_nxt      = ridx_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    best_data_nxt = best_data_r;
    hold_nxt      = hold_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_entry      = hold_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[AW-1:0];
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          hold_nxt = req_entry;
          ptr_nxt  = '0;
          if (is_deq) begin
            res_nxt.data_out = '0;
            res_nxt.status   = (cnt_r == '0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_DEQ;
          end else begin
            res_nxt.data_out = '0;
            res_nxt.status   = (cnt_r == CNT_FULL) ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
          end
        end
      end
      spq_pkg::S_ENQ: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      spq_pkg::S_SCAN: begin
        if (issue) begin
          rd_en    = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
          rvld_nxt = 1'b1;
          ridx_nxt = ptr_r[AW-1:0];
        end
        if (take_best) begin
          best_idx_nxt  = ridx_r;
          best_pri_nxt  = rd_entry.prio;
          best_data_nxt = rd_entry.data;
        end
        if (scan_last) begin
          rd_en            = 1'b0;
          rvld_nxt         = 1'b0;
          ptr_nxt          = CW'(best_idx_nxt) + CW'(1);
          res_nxt.data_out = best_data_nxt;
        end
      end
      spq_pkg::S_SHIFT: begin
        if (issue) begin
          rd_en    = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
          rvld_nxt = 1'b1;
          ridx_nxt = ptr_r[AW-1:0];
        end
        if (rvld_r) begin
          wr_en    = 1'b1;
          wr_addr  = ridx_r - AW'(1);
          wr_entry = rd_entry;
        end
        if (shift_done) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
      cnt_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    ridx_r      <= ridx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pri_r  <= best_pri_nxt;
    best_data_r <= best_data_nxt;
    hold_r      <= hold_nxt;
    res_r       <= res_nxt;
  end

  assign req_stall = (state_r != spq_pkg::S_IDLE);
  assign res_valid = (state_r == spq_pkg::S_RESP);
  assign res       = res_r;

endmodule

`default_nettype wire

[hdl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_port_checker
// Port-level checks for the stable max priority queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_port_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_data_out,
  input wire logic [1:0]         out_status
);

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken request blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // only a successful dequeue carries data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != spq_pkg::ST_DEQ) |-> out_data_out == '0)
    else $error("nonzero data without a dequeue");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind stable_max_priority_queue spq_port_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_data_out (out_data_out),
  .out_status   (out_status)
);

`default_nettype wire

[sim/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the stable max priority queue. Every accepted
// request is applied to a private copy of the entry store, which gives the
// expected result. Each accepted result is compared field by field with the
// oldest expected one. Mismatches are counted, and the number of results
// still owed is handed back to the testbench.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_data_in,
  input  logic signed [31:0] in_priority_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_data_out,
  input  logic [1:0]         out_status,
  input  logic               end_of_run,
  output int                 fail_count,
  output int                 pending
);
  import spq_pkg::*;

  localparam int PRINT_LIMIT = 100;

  logic signed [31:0] slot_data [CAPACITY];
  logic signed [31:0] slot_prio [CAPACITY];
  int unsigned        slot_count;
  res_t               result_q [$];
  logic               end_checked;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // apply one request to the shadow store and return the result it yields
  function automatic res_t serve_request(input op_t op, input logic signed [31:0] word,
                                         input logic signed [31:0] prio);
    res_t        r;
    int unsigned best;
    int unsigned i;
    r.data_out = '0;
    if (op == OP_ENQ) begin
      if (slot_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        slot_data[slot_count] = word;
        slot_prio[slot_count] = prio;
        slot_count++;
        r.status = ST_ENQ;
      end
    end else if (slot_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // earliest entry wins among equal priorities
      best = 0;
      for (i = 1; i < slot_count; i++) begin
        if (slot_prio[i] > slot_prio[best]) best = i;
      end
      r.data_out = slot_data[best];
      for (i = best; i + 1 < slot_count; i++) begin
        slot_data[i] = slot_data[i + 1];
        slot_prio[i] = slot_prio[i + 1];
      end
      slot_count--;
      r.status = ST_DEQ;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      slot_count = 0;
      result_q.delete();
      fail_count = 0;
      end_checked = 1'b0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(serve_request(op_t'(in_operation), in_data_in, in_priority_in));
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result data_out %0d status %0d with no request waiting",
                                    out_data_out, out_status));
        end else begin
          want = result_q.pop_front();
          if (out_data_out !== want.data_out) begin
            report_mismatch($sformatf("data_out %0d, expected %0d", out_data_out,
                                      want.data_out));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          end
        end
      end
      if (end_of_run && !end_checked) begin
        end_checked = 1'b1;
        if (result_q.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", result_q.size()));
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

[sim/tb_stable_max_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_stable_max_priority_queue
// Stimulus and verdict for the stable max priority queue. A directed part
// covers empty and full status, extreme priorities and data, and ties; then
// random segments alternate between filling, draining and balanced traffic
// with random gaps and receiver stalls, one quiet segment, one long receiver
// hold-off and pauses until the queue of results has drained. Checking is
// done by spq_checker.
// ----------------------------------------------------------------------------
module tb_stable_max_priority_queue;
  import spq_pkg::*;

  localparam int unsigned CAPACITY       = 16;
  localparam int          SEGMENTS       = 15;
  localparam int          SEG_ITEMS      = 102;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          LONG_HOLD      = 300;
  localparam int          DRAIN_CYCLES   = 60;
  localparam int          IDLE_PCT       = 28;

  localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] EDGE_WORDS [4] = '{PRIO_MIN, 32'sd0, -32'sd1, PRIO_MAX};
  localparam logic signed [31:0] PRIO_CYCLE [4] = '{32'sd0, PRIO_MIN, PRIO_MAX, -32'sd1};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_operation = 1'b0;
  logic signed [31:0] in_data_in = '0;
  logic signed [31:0] in_priority_in = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] out_data_out;
  logic [1:0]         out_status;

  logic hold_req = 1'b0;
  logic quiet = 1'b0;
  logic end_of_run = 1'b0;
  int   hold_cycles = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  always #10 clk = ~clk;

  stable_max_priority_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_in     (in_data_in),
    .in_priority_in (in_priority_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_status     (out_status)
  );

  spq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_in     (in_data_in),
    .in_priority_in (in_priority_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .end_of_run     (end_of_run),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_cycles <= LONG_HOLD;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(input op_t op, input logic signed [31:0] word,
                          input logic signed [31:0] prio);
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_in <= word;
    in_priority_in <= prio;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) n++;
      if (n != 0) idle_gap(n);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic start_hold();
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
  endtask

  // mostly small values so that ties are common, plus the extremes
  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        v = $urandom_range(0, 6);
        v = v - 32'sd3;
      end
      5:       v = PRIO_MAX;
      6:       v = PRIO_MIN;
      7:       v = PRIO_MIN + $urandom_range(0, 2);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int seg;
    int k;
    int enq_pct;
    op_t op;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, lowest priority alone, fill with ties, full, serve
    send_req(OP_DEQ, $urandom, $urandom);
    send_req(OP_ENQ, PRIO_MAX, PRIO_MIN);
    send_req(OP_DEQ, $urandom, $urandom);
    for (k = 0; k < CAPACITY; k++) begin
      send_req(OP_ENQ, (k < 4) ? EDGE_WORDS[k] : $urandom, PRIO_CYCLE[k % 4]);
    end
    send_req(OP_ENQ, $urandom, PRIO_MAX);
    for (k = 0; k < 5; k++) begin
      send_req(OP_DEQ, $urandom, $urandom);
    end
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      enq_pct = (seg % 3 == 0) ? 75 : (seg % 3 == 1) ? 25 : 50;
      quiet <= (seg == 4);
      if (seg == 2) start_hold();
      if (seg == 7 || seg == 11) wait_drained();
      for (k = 0; k < SEG_ITEMS; k++) begin
        op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_req(op, $urandom, pick_priority());
        sender_gap();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
